FILE: hdl/gmv_pkg.sv
package gmv_pkg;

   localparam int DIM         = 128;
   localparam int HALF_W      = DIM / 2;
   localparam int IDX_W       = $clog2(DIM);
   localparam int OP_W        = 2;
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = DIM / GROUP_SIZE;
   localparam int NUM_MIDS    = 4;
   localparam int MID_SIZE    = NUM_GROUPS / NUM_MIDS;

   localparam logic [OP_W-1:0] OP_LOAD_COL = OP_W'(0);
   localparam logic [OP_W-1:0] OP_LOAD_ROW = OP_W'(1);
   localparam logic [OP_W-1:0] OP_APPLY    = OP_W'(2);

   typedef logic [DIM-1:0][DIM-1:0]        matrix_type;
   typedef logic [NUM_GROUPS-1:0][DIM-1:0] group_sum_type;
   typedef logic [NUM_MIDS-1:0][DIM-1:0]   mid_sum_type;

   typedef struct packed {
      logic             col_wr;
      logic             row_wr;
      logic [IDX_W-1:0] index;
      logic [DIM-1:0]   value;
   } load_cmd_type;

endpackage

FILE: hdl/gf2_matrix_vector_multiply_unit.sv
// Channel | Direction | Transfer contents
// req     | in        | operation, line_index, value_low, value_high
// rsp     | out       | product_low, product_high (one per apply)
//
// One item may be transferred in every cycle while req_stall is low; results come out in order.
// The depth is set by the input register and the three stages of the column XOR tree.
// Loads take effect on the matrix as they leave the input register, so later applies see them.
// Reset clears the whole matrix and all valid bits.
// A stalled result holds its stage, and earlier stages keep filling any bubbles behind it.
module gf2_matrix_vector_multiply_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gmv_pkg::OP_W-1:0]       req_operation,
   input  logic [gmv_pkg::IDX_W-1:0]      req_line_index,
   input  logic [gmv_pkg::HALF_W-1:0]     req_value_low,
   input  logic [gmv_pkg::HALF_W-1:0]     req_value_high,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gmv_pkg::HALF_W-1:0]     rsp_product_low,
   output logic [gmv_pkg::HALF_W-1:0]     rsp_product_high
);

   logic                          v0_ff, v0_in;
   logic [gmv_pkg::OP_W-1:0]      op0_ff, op0_in;
   logic [gmv_pkg::IDX_W-1:0]     idx0_ff, idx0_in;
   logic [gmv_pkg::DIM-1:0]       val0_ff, val0_in;

   logic                          v1_ff, v1_in;
   gmv_pkg::group_sum_type        part1_ff, part1_in;
   logic                          v2_ff, v2_in;
   gmv_pkg::mid_sum_type          part2_ff, part2_in;
   logic                          v3_ff, v3_in;
   logic [gmv_pkg::DIM-1:0]       prod_ff, prod_in;

   logic                          ready0, ready1, ready2, ready3, fire0;
   gmv_pkg::load_cmd_type         load_cmd;
   gmv_pkg::matrix_type           columns;
   gmv_pkg::group_sum_type        group_sum;
   gmv_pkg::mid_sum_type          mid_sum;
   logic [gmv_pkg::DIM-1:0]       total_sum;

   gmv_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .load_cmd (load_cmd),
      .columns  (columns)
   );

   always_comb begin
      ready3 = !v3_ff || !rsp_stall;
      ready2 = !v2_ff || ready3;
      ready1 = !v1_ff || ready2;
      ready0 = !v0_ff || ready1;
      fire0  = v0_ff && ready1;
   end

   assign req_stall = !ready0;

   always_comb begin
      load_cmd.col_wr = fire0 && (op0_ff == gmv_pkg::OP_LOAD_COL);
      load_cmd.row_wr = fire0 && (op0_ff == gmv_pkg::OP_LOAD_ROW);
      load_cmd.index  = idx0_ff;
      load_cmd.value  = val0_ff;
   end

   always_comb begin
      for (int g = 0; g < gmv_pkg::NUM_GROUPS; g++) begin
         group_sum[g] = '0;
         for (int k = 0; k < gmv_pkg::GROUP_SIZE; k++) begin
            if (val0_ff[g * gmv_pkg::GROUP_SIZE + k]) begin
               group_sum[g] = group_sum[g] ^ columns[g * gmv_pkg::GROUP_SIZE + k];
            end
         end
      end
      for (int m = 0; m < gmv_pkg::NUM_MIDS; m++) begin
         mid_sum[m] = '0;
         for (int k = 0; k < gmv_pkg::MID_SIZE; k++) begin
            mid_sum[m] = mid_sum[m] ^ part1_ff[m * gmv_pkg::MID_SIZE + k];
         end
      end
      total_sum = '0;
      for (int m = 0; m < gmv_pkg::NUM_MIDS; m++) begin
         total_sum = total_sum ^ part2_ff[m];
      end
   end

   always_comb begin
      v0_in   = ready0 ? req_valid : v0_ff;
      op0_in  = ready0 ? req_operation : op0_ff;
      idx0_in = ready0 ? req_line_index : idx0_ff;
      val0_in = ready0 ? {req_value_high, req_value_low} : val0_ff;

      v1_in    = ready1 ? (fire0 && (op0_ff == gmv_pkg::OP_APPLY)) : v1_ff;
      part1_in = ready1 ? group_sum : part1_ff;

      v2_in    = ready2 ? v1_ff : v2_ff;
      part2_in = ready2 ? mid_sum : part2_ff;

      v3_in   = ready3 ? v2_ff : v3_ff;
      prod_in = ready3 ? total_sum : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      op0_ff   <= op0_in;
      idx0_ff  <= idx0_in;
      val0_ff  <= val0_in;
      part1_ff <= part1_in;
      part2_ff <= part2_in;
      prod_ff  <= prod_in;
   end

   assign rsp_valid        = v3_ff;
   assign rsp_product_low  = prod_ff[gmv_pkg::HALF_W-1:0];
   assign rsp_product_high = prod_ff[gmv_pkg::DIM-1:gmv_pkg::HALF_W];

`ifndef ASSERT_OFF
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (fire0 && (op0_ff != gmv_pkg::OP_APPLY)) |=> !v1_ff)
      else $error("A non-apply item entered the reduction pipeline.");

   a_apply_enters: assert property (@(posedge clock) disable iff (reset)
      (fire0 && (op0_ff == gmv_pkg::OP_APPLY)) |=> v1_ff)
      else $error("An apply was lost on leaving the input register.");

   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v0_ff)
      else $error("Input stalled with an empty input register.");

   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !ready3) |=> (v2_ff && $stable(part2_ff)))
      else $error("A blocked partial sum changed or vanished.");
`endif

endmodule

FILE: hdl/gmv_matrix.sv
module gmv_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  gmv_pkg::load_cmd_type load_cmd,
   output gmv_pkg::matrix_type  columns
);

   gmv_pkg::matrix_type col_ff;
   gmv_pkg::matrix_type col_in;

   always_comb begin
      col_in = col_ff;
      for (int c = 0; c < gmv_pkg::DIM; c++) begin
         if (load_cmd.col_wr && (load_cmd.index == gmv_pkg::IDX_W'(c))) begin
            col_in[c] = load_cmd.value;
         end else if (load_cmd.row_wr) begin
            col_in[c][load_cmd.index] = load_cmd.value[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign columns = col_ff;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import gmv_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = OP_W'(3);
   localparam int RESET_CYCLES    = 6;
   localparam int DRAIN_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 530;
   localparam int HOLD_CYCLES     = 80;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_operation    = OP_APPLY;
   logic [IDX_W-1:0]  req_line_index   = '0;
   logic [HALF_W-1:0] req_value_low    = '0;
   logic [HALF_W-1:0] req_value_high   = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [HALF_W-1:0] rsp_product_low;
   logic [HALF_W-1:0] rsp_product_high;

   logic [DIM-1:0] column_model [DIM];
   logic [DIM-1:0] pending_products [$];

   int send_idle_pct  = 0;
   int rsp_idle_pct   = 0;
   int hold_request   = 0;
   int stall_left     = 0;
   int mismatch_count = 0;
   int column_loads   = 0;
   int row_loads      = 0;
   int applies        = 0;
   int ignored_items  = 0;
   int checked_count  = 0;

   gf2_matrix_vector_multiply_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_line_index   (req_line_index),
      .req_value_low    (req_value_low),
      .req_value_high   (req_value_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_product_low  (rsp_product_low),
      .rsp_product_high (rsp_product_high)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("gf2_matrix_vector_multiply_unit: mismatch");
      $finish;
   end

   function automatic logic [DIM-1:0] predict_product(input logic [DIM-1:0] vec);
      logic [DIM-1:0] acc;
      acc = '0;
      for (int j = 0; j < DIM; j++) begin
         if (vec[j]) begin
            acc ^= column_model[j];
         end
      end
      return acc;
   endfunction

   function automatic logic [DIM-1:0] random_vector();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         return '0;
      end else if (pick < 10) begin
         return '1;
      end else if (pick < 25) begin
         return DIM'(1) << $urandom_range(DIM - 1);
      end else if (pick < 40) begin
         return {$urandom, $urandom, $urandom, $urandom} &
                {$urandom, $urandom, $urandom, $urandom};
      end
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [DIM-1:0] vec);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_line_index <= idx;
      req_value_low  <= vec[HALF_W-1:0];
      req_value_high <= vec[DIM-1:HALF_W];
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      case (op)
         OP_LOAD_COL: begin
            column_model[idx] = vec;
            column_loads++;
         end
         OP_LOAD_ROW: begin
            for (int c = 0; c < DIM; c++) begin
               column_model[c][idx] = vec[c];
            end
            row_loads++;
         end
         OP_APPLY: begin
            pending_products.push_back(predict_product(vec));
            applies++;
         end
         default: begin
            ignored_items++;
         end
      endcase
   endtask

   task automatic test_directed_cases();
      send_item(OP_APPLY, '0, '1);
      send_item(OP_LOAD_COL, IDX_W'(0), '1);
      send_item(OP_LOAD_COL, IDX_W'(DIM - 1), random_vector());
      send_item(OP_LOAD_COL, IDX_W'(HALF_W), {$urandom, $urandom, $urandom, $urandom});
      send_item(OP_LOAD_ROW, IDX_W'(0), '1);
      send_item(OP_LOAD_ROW, IDX_W'(DIM - 1), {$urandom, $urandom, $urandom, $urandom});
      send_item(OP_LOAD_ROW, IDX_W'(HALF_W - 1), {$urandom, $urandom, $urandom, $urandom});
      send_item(OP_LOAD_ROW, IDX_W'(HALF_W), {$urandom, $urandom, $urandom, $urandom});
      send_item(OP_APPLY, IDX_W'(DIM - 1), '0);
      send_item(OP_APPLY, '0, DIM'(1));
      send_item(OP_APPLY, '0, DIM'(1) << (HALF_W - 1));
      send_item(OP_APPLY, '0, DIM'(1) << HALF_W);
      send_item(OP_APPLY, '0, DIM'(1) << (DIM - 1));
      send_item(OP_APPLY, '1, '1);
      send_item(OP_UNUSED, IDX_W'(0), '1);
      send_item(OP_UNUSED, IDX_W'(DIM - 1), {$urandom, $urandom, $urandom, $urandom});
      send_item(OP_APPLY, '0, '1);
      send_item(OP_LOAD_COL, IDX_W'(5), '0);
      send_item(OP_APPLY, '0, {$urandom, $urandom, $urandom, $urandom});
      send_item(OP_LOAD_ROW, IDX_W'(10), '1);
      send_item(OP_APPLY, '0, {$urandom, $urandom, $urandom, $urandom});
      send_item(OP_APPLY, '0, '1);
   endtask

   task automatic test_random_traffic(input int count, input int sender_pct,
                                      input int receiver_pct);
      int pick;
      logic [OP_W-1:0] op;
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            op = OP_LOAD_COL;
         end else if (pick < 45) begin
            op = OP_LOAD_ROW;
         end else if (pick < 95) begin
            op = OP_APPLY;
         end else begin
            op = OP_UNUSED;
         end
         send_item(op, IDX_W'($urandom_range(DIM - 1)), random_vector());
      end
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_request  = HOLD_CYCLES;
      for (int n = 0; n < 40; n++) begin
         if (n % 8 == 3) begin
            send_item(OP_LOAD_ROW, IDX_W'($urandom_range(DIM - 1)), random_vector());
         end else begin
            send_item(OP_APPLY, '0, random_vector());
         end
      end
   endtask

   always @(posedge clock) begin : result_side
      logic [DIM-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_products.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual low %h high %h",
                     $time, rsp_product_low, rsp_product_high);
            mismatch_count++;
         end else begin
            want = pending_products.pop_front();
            checked_count++;
            if (rsp_product_low !== want[HALF_W-1:0]) begin
               $display("%0t: product_low expected %h, actual %h",
                        $time, want[HALF_W-1:0], rsp_product_low);
               mismatch_count++;
            end
            if (rsp_product_high !== want[DIM-1:HALF_W]) begin
               $display("%0t: product_high expected %h, actual %h",
                        $time, want[DIM-1:HALF_W], rsp_product_high);
               mismatch_count++;
            end
         end
      end
      if (hold_request != 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin
      foreach (column_model[c]) begin
         column_model[c] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(ITEMS_PER_PHASE, 31, 50);
      test_output_backpressure();
      test_random_traffic(ITEMS_PER_PHASE, 50, 31);
      test_random_traffic(ITEMS_PER_PHASE, 0, 0);
      req_valid <= 1'b0;
      while (pending_products.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d column loads, %0d row loads, %0d applies and %0d ignored items.",
               column_loads, row_loads, applies, ignored_items);
      $display("Checked %0d products under random idling and a long output hold-off.",
               checked_count);
      if (mismatch_count == 0) begin
         $display("gf2_matrix_vector_multiply_unit: match");
      end else begin
         $display("gf2_matrix_vector_multiply_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: gf2_matrix_vector_multiply_unit.f
hdl/gmv_pkg.sv
hdl/gmv_matrix.sv
hdl/gf2_matrix_vector_multiply_unit.sv
tb/sv/tb.sv
